FILE: hw/rtl/vta_pkg.sv
package vta_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int TRIG_WIDTH     = 16;
   localparam int TRIG_FRAC_BITS = 14;

   localparam int PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int RND_WIDTH   = SUM_WIDTH - TRIG_FRAC_BITS;
   localparam int TOTAL_WIDTH = RND_WIDTH + 1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COORD_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [TOTAL_WIDTH-1:0] total_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam trig_type  TRIG_ONE  = trig_type'(2 ** TRIG_FRAC_BITS);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_ANGLE = 3'd0,
      CSR_SIN_ANGLE = 3'd1,
      CSR_OFFSET_X  = 3'd2,
      CSR_OFFSET_Y  = 3'd3,
      CSR_OFFSET_Z  = 3'd4
   } csr_index_type;

   typedef struct packed {
      coord_type  pos_x;
      coord_type  pos_y;
      coord_type  pos_z;
      logic       last_vertex;
   } req_type;

   typedef struct packed {
      coord_type  box_min_x;
      coord_type  box_min_y;
      coord_type  box_min_z;
      coord_type  box_max_x;
      coord_type  box_max_y;
      coord_type  box_max_z;
   } rsp_type;

   typedef struct packed {
      trig_type   cos_angle;
      trig_type   sin_angle;
      coord_type  offset_x;
      coord_type  offset_y;
      coord_type  offset_z;
   } cfg_type;

   // transformed vertex handed to the bounding stage
   typedef struct packed {
      coord_type  tx;
      coord_type  ty;
      coord_type  tz;
      logic       last;
   } xfm_type;

   function automatic coord_type saturate(input total_type v);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &v[TOTAL_WIDTH-1:COORD_WIDTH-1];
      hi_zeros = ~(|v[TOTAL_WIDTH-1:COORD_WIDTH-1]);
      if (hi_ones || hi_zeros) begin
         return v[COORD_WIDTH-1:0];
      end
      return v[TOTAL_WIDTH-1] ? COORD_MIN : COORD_MAX;
   endfunction

endpackage

FILE: hw/rtl/vta_xform.sv
module vta_xform (
   input  logic               clock,
   input  logic               reset,
   input  vta_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  vta_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output vta_pkg::xfm_type   out_data
);

   localparam int SW = vta_pkg::SUM_WIDTH;
   localparam int TW = vta_pkg::TOTAL_WIDTH;
   localparam logic signed [SW-1:0] HALF = SW'(2 ** (vta_pkg::TRIG_FRAC_BITS - 1));

   // stage 1: input register
   logic              s1_valid_ff;
   vta_pkg::req_type  s1_data_ff;

   // stage 2: rotation products
   logic                s2_valid_ff;
   vta_pkg::prod_type   xc_ff, zs_ff, zc_ff, xs_ff;
   vta_pkg::coord_type  ty_ff;
   logic                s2_last_ff;

   // stage 3: transformed vertex
   logic              s3_valid_ff;
   vta_pkg::xfm_type  s3_data_ff;

   logic s1_ready, s2_ready, s3_ready;

   vta_pkg::prod_type   xc_in, zs_in, zc_in, xs_in;
   vta_pkg::coord_type  ty_in;
   vta_pkg::xfm_type    s3_data_in;

   logic signed [SW-1:0] sum_x, sum_z, rnd_x, rnd_z;
   vta_pkg::total_type   tot_x, tot_z, tot_y;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      xc_in = s1_data_ff.pos_x * cfg.cos_angle;
      zs_in = s1_data_ff.pos_z * cfg.sin_angle;
      zc_in = s1_data_ff.pos_z * cfg.cos_angle;
      xs_in = s1_data_ff.pos_x * cfg.sin_angle;
      tot_y = TW'(s1_data_ff.pos_y) + TW'(cfg.offset_y);
      ty_in = vta_pkg::saturate(tot_y);
   end

   always_comb begin
      sum_x = SW'(xc_ff) + SW'(zs_ff);
      sum_z = SW'(zc_ff) - SW'(xs_ff);
      rnd_x = sum_x + HALF;
      rnd_z = sum_z + HALF;
      tot_x = TW'($signed(rnd_x[SW-1:vta_pkg::TRIG_FRAC_BITS])) + TW'(cfg.offset_x);
      tot_z = TW'($signed(rnd_z[SW-1:vta_pkg::TRIG_FRAC_BITS])) + TW'(cfg.offset_z);
      s3_data_in.tx   = vta_pkg::saturate(tot_x);
      s3_data_in.ty   = ty_ff;
      s3_data_in.tz   = vta_pkg::saturate(tot_z);
      s3_data_in.last = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_data_ff <= in_data;
      end
      if (s1_valid_ff && s2_ready) begin
         xc_ff      <= xc_in;
         zs_ff      <= zs_in;
         zc_ff      <= zc_in;
         xs_ff      <= xs_in;
         ty_ff      <= ty_in;
         s2_last_ff <= s1_data_ff.last_vertex;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

FILE: hw/rtl/vta_bound.sv
module vta_bound (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vta_pkg::xfm_type   in_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vta_pkg::rsp_type   rsp_data
);

   vta_pkg::rsp_type  box_ff, box_in, grown;
   vta_pkg::rsp_type  rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free, go;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_ready = !in_data.last || out_free;
   assign go       = in_valid && in_ready;

   always_comb begin
      grown = box_ff;
      if (in_data.tx < box_ff.box_min_x) grown.box_min_x = in_data.tx;
      if (in_data.ty < box_ff.box_min_y) grown.box_min_y = in_data.ty;
      if (in_data.tz < box_ff.box_min_z) grown.box_min_z = in_data.tz;
      if (in_data.tx > box_ff.box_max_x) grown.box_max_x = in_data.tx;
      if (in_data.ty > box_ff.box_max_y) grown.box_max_y = in_data.ty;
      if (in_data.tz > box_ff.box_max_z) grown.box_max_z = in_data.tz;

      box_in = box_ff;
      if (go) begin
         if (in_data.last) begin
            box_in.box_min_x = vta_pkg::COORD_MAX;
            box_in.box_min_y = vta_pkg::COORD_MAX;
            box_in.box_min_z = vta_pkg::COORD_MAX;
            box_in.box_max_x = vta_pkg::COORD_MIN;
            box_in.box_max_y = vta_pkg::COORD_MIN;
            box_in.box_max_z = vta_pkg::COORD_MIN;
         end else begin
            box_in = grown;
         end
      end

      rsp_valid_in = (go && in_data.last) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         box_ff.box_min_x <= vta_pkg::COORD_MAX;
         box_ff.box_min_y <= vta_pkg::COORD_MAX;
         box_ff.box_min_z <= vta_pkg::COORD_MAX;
         box_ff.box_max_x <= vta_pkg::COORD_MIN;
         box_ff.box_max_y <= vta_pkg::COORD_MIN;
         box_ff.box_max_z <= vta_pkg::COORD_MIN;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         box_ff       <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && in_data.last) begin
         rsp_data_ff <= grown;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/vertex_transform_aabb.sv
// Bounding box of a rotated and translated mesh.
// Request channel (req_valid / req_stall / req_data): one vertex position per
// request, Q16.16, with last_vertex set on the final vertex of the mesh.
// Response channel (rsp_valid / rsp_stall / rsp_data): one box per mesh, the
// per-axis min and max of all transformed vertices including the last one.
// Each vertex gets x' = x*cos + z*sin + tx, y' = y + ty, z' = -x*sin + z*cos + tz,
// rounded half up to Q16.16 and saturated to 32 bits.
// csr_write_enable / csr_index / csr_data write cos_angle, sin_angle (Q2.14)
// and offset_x/y/z; write only while no vertex is in flight.
// Throughput: one request per cycle while req_stall is low. Pipeline: four
// registers (input, products, transformed vertex, response), which a last vertex
// passes in that order before its box shows on rsp_valid.
// A stalled response holds; the pipeline keeps taking vertices that are not
// last, and req_stall rises only when a last vertex must wait for the
// response register.
// Reset (synchronous) empties the pipeline, empties the box and restores
// cos_angle = 1.0 with zero sine and zero offsets.
module vertex_transform_aabb (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  vta_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output vta_pkg::rsp_type                        rsp_data,
   input  logic                                    csr_write_enable,
   input  logic [vta_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [vta_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   vta_pkg::cfg_type  cfg_ff;
   logic              req_ready;
   logic              xfm_valid, xfm_ready;
   vta_pkg::xfm_type  xfm_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle <= vta_pkg::TRIG_ONE;
         cfg_ff.sin_angle <= '0;
         cfg_ff.offset_x  <= '0;
         cfg_ff.offset_y  <= '0;
         cfg_ff.offset_z  <= '0;
      end else if (csr_write_enable) begin
         case (vta_pkg::csr_index_type'(csr_index))
            vta_pkg::CSR_COS_ANGLE: cfg_ff.cos_angle <= csr_data[vta_pkg::TRIG_WIDTH-1:0];
            vta_pkg::CSR_SIN_ANGLE: cfg_ff.sin_angle <= csr_data[vta_pkg::TRIG_WIDTH-1:0];
            vta_pkg::CSR_OFFSET_X:  cfg_ff.offset_x  <= csr_data;
            vta_pkg::CSR_OFFSET_Y:  cfg_ff.offset_y  <= csr_data;
            vta_pkg::CSR_OFFSET_Z:  cfg_ff.offset_z  <= csr_data;
            default: ;
         endcase
      end
   end

   vta_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (xfm_valid),
      .out_ready (xfm_ready),
      .out_data  (xfm_data)
   );

   vta_bound u_bound (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xfm_valid),
      .in_ready  (xfm_ready),
      .in_data   (xfm_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !req_ready;

   // back-pressure only ever comes from a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   // a last vertex leaving the transform always yields a response
   assert property (@(posedge clock) disable iff (reset)
      (xfm_valid && xfm_ready && xfm_data.last) |=> rsp_valid)
      else $error("closing vertex produced no response");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
